[design/lrups_pkg.sv]
// ----------------------------------------------------------------------------
// LRU replacement stack package
// Commands, widths and the token that travels along the cell chain.
// ----------------------------------------------------------------------------
package lrups_pkg;

   localparam int FRAME_W = 6;
   localparam int CFG_W   = 7;

   localparam logic CMD_REFERENCE = 1'b0;
   localparam logic CMD_EVICT     = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic               refd;
      logic [FRAME_W-1:0] frame;
      logic               carry_valid;
      logic [FRAME_W-1:0] carry_frame;
      logic               done;
      logic               found;
   } lrups_token_type;

endpackage

[design/lrups_cell.sv]
// ----------------------------------------------------------------------------
// LRU stack cell
// One stack slot; swaps with the passing token on reference, tracks the
// oldest valid frame on evict, and registers the token to the next cell.
// ----------------------------------------------------------------------------
module lrups_cell
   import lrups_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int DEPTH_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DEPTH_W-1:0]   depth,
   input  lrups_token_type      tok_i,
   output lrups_token_type      tok_o
);

   localparam logic [DEPTH_W-1:0] POS      = DEPTH_W'(INDEX);
   localparam logic [DEPTH_W-1:0] POS_NEXT = DEPTH_W'(INDEX + 1);

   logic               slot_valid_ff;
   logic               slot_valid_in;
   logic [FRAME_W-1:0] slot_frame_ff;
   logic [FRAME_W-1:0] slot_frame_in;
   lrups_token_type    tok_ff;
   lrups_token_type    tok_in;
   logic               active;
   logic               last;

   assign active = POS < depth;
   assign last   = POS_NEXT == depth;

   always_comb begin
      tok_in        = tok_i;
      slot_valid_in = slot_valid_ff;
      slot_frame_in = slot_frame_ff;
      if (tok_i.valid && active) begin
         if (tok_i.cmd == CMD_EVICT) begin
            if (slot_valid_ff) begin
               tok_in.carry_frame = slot_frame_ff;
               tok_in.found       = 1'b1;
            end
         end else if (!tok_i.done) begin
            slot_valid_in      = tok_i.carry_valid;
            slot_frame_in      = tok_i.carry_frame;
            tok_in.carry_valid = slot_valid_ff;
            tok_in.carry_frame = slot_frame_ff;
            if (tok_i.refd && slot_valid_ff && (slot_frame_ff == tok_i.frame)) begin
               tok_in.done  = 1'b1;
               tok_in.found = 1'b1;
            end
            if (last) begin
               tok_in.done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_frame_ff <= slot_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

   a_slot_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && tok_i.valid && (tok_i.cmd == CMD_REFERENCE))
      |=> $stable(slot_valid_ff))
      else $error("slot changed without a reference token");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && tok_i.valid && tok_i.done |=> tok_ff.done)
      else $error("finished reference lost its done flag");

endmodule

[design/lru_page_replacement_stack_core.sv]
// ----------------------------------------------------------------------------
// LRU page replacement stack
// Exact LRU ordering of page frames kept in a chain of slot cells.
// ----------------------------------------------------------------------------
// Each transaction walks the chain of MAX_FRAMES slot cells, one cell per
// cycle while the chain advances, and its response is registered from the
// last cell's token. Transactions enter back to back, one per cycle, since
// each cell updates its slot as the token passes; the whole chain stalls only
// when a response is ready while the previous one is still held at the output.
module lru_page_replacement_stack_core
   import lrups_pkg::*;
#(
   parameter int MAX_FRAMES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [5:0] frame_number, [6] referenced_before
   input  logic             req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] victim_frame, [6] found
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int DEPTH_W = ($clog2(MAX_FRAMES + 1) > CFG_W) ?
                            $clog2(MAX_FRAMES + 1) : CFG_W;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(MAX_FRAMES);
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = (MAX_FRAMES < 64) ?
                                                DEPTH_W'(MAX_FRAMES) : DEPTH_W'(64);

   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] wr_ext;
   logic               advance;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic [7:0]         rsp_data_in;
   lrups_token_type    chain [MAX_FRAMES+1];
   lrups_token_type    tok_end;

   assign csr_ready = 1'b1;
   assign wr_ext    = DEPTH_W'(csr_wdata);

   always_comb begin
      depth_in = wr_ext;
      if (wr_ext == '0) begin
         depth_in = DEPTH_W'(1);
      end else if (wr_ext > DEPTH_MAX) begin
         depth_in = DEPTH_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         depth_ff <= depth_in;
      end
   end

   assign tok_end    = chain[MAX_FRAMES];
   assign advance    = !(tok_end.valid && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;

   always_comb begin
      chain[0].valid       = req_tvalid && req_tready;
      chain[0].cmd         = req_tuser;
      chain[0].refd        = req_tdata[6];
      chain[0].frame       = req_tdata[5:0];
      chain[0].carry_valid = (req_tuser == CMD_REFERENCE);
      chain[0].carry_frame = (req_tuser == CMD_REFERENCE) ? req_tdata[5:0] : '0;
      chain[0].done        = 1'b0;
      chain[0].found       = 1'b0;
   end

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      lrups_cell #(
         .INDEX   (i),
         .DEPTH_W (DEPTH_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .depth   (depth_ff),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in[6]   = tok_end.found;
      if (tok_end.cmd == CMD_EVICT) begin
         rsp_data_in[5:0] = tok_end.carry_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tok_end.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tok_end.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      (depth_ff != '0) && (depth_ff <= DEPTH_MAX))
      else $error("active depth out of range");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> tok_end.valid && $stable(tok_end.found))
      else $error("chain moved during a stall");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      tok_end.valid && rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("pending response dropped");

endmodule
